[design/utt_pkg.sv]
// shared types and constants for the utf-8 to utf-16 transcoder
package utt_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [1:0]             rcount_t;
  typedef logic [QPTR_W-1:0]      qptr_t;
  typedef logic [QPTR_W:0]        qlevel_t;

  localparam cnt_t         COUNT_MAX   = '1;
  localparam qlevel_t      QUEUE_FULL  = qlevel_t'(QUEUE_DEPTH);
  localparam logic [15:0]  REPLACEMENT = 16'hFFFD;
  localparam logic [15:0]  HIGH_SURR   = 16'hD800;
  localparam logic [15:0]  LOW_SURR    = 16'hDC00;
  localparam logic [20:0]  SUPP_BASE   = 21'h10000;
  localparam logic [7:0]   CONT_LOW    = 8'h80;
  localparam logic [7:0]   CONT_HIGH   = 8'hBF;

  // one result as it leaves the block
  typedef struct packed {
    logic [15:0] code_unit;
    cnt_t        unit_position;
    logic        is_finish;
    cnt_t        units_written;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    rcount_t                    n;
    res_t [MAX_RESULTS-1:0]     res;
  } pkt_t;

  typedef struct packed {
    logic valid;
    pkt_t pkt;
  } push_t;

  typedef struct packed {
    logic    full;
    logic    empty;
    qlevel_t level;
  } q_status_t;

endpackage

[design/utt_if.sv]
// byte and code unit channel interfaces
interface utt_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [15:0] unit_budget;
  logic [15:0] start_position;

  modport source (output valid, data_byte, first_byte, unit_budget, start_position,
                  input ready);
  modport sink (input valid, data_byte, first_byte, unit_budget, start_position,
                output ready);
endinterface

interface utt_out_if;
  logic          valid;
  logic          ready;
  logic [15:0]   code_unit;
  utt_pkg::cnt_t unit_position;
  logic          is_finish;
  utt_pkg::cnt_t units_written;

  modport source (output valid, code_unit, unit_position, is_finish, units_written,
                  input ready);
  modport sink (input valid, code_unit, unit_position, is_finish, units_written,
                output ready);
endinterface

[design/utf8_to_utf16_transcoder.sv]
// top level of the utf-8 to utf-16 transcoder
// Takes one UTF-8 byte per beat and gives UTF-16 code units, each with its
// destination position and running count, plus one finish result per string.
// A byte is accepted in the cycle it is offered whenever the four-entry packet
// queue between the decoder and the output serializer has room, so the input
// runs at one byte per cycle. Each byte yields zero to three results, and the
// output register sends one result per cycle while the receiver is ready, so a
// byte with k results gives k output beats; the queue absorbs bursts and the
// input stalls only when it is full. No clearing pass is needed after reset.
module utf8_to_utf16_transcoder (
  input  logic       clk,
  input  logic       rst,
  utt_in_if.sink     byte_in,
  utt_out_if.source  unit_out
);

  utt_pkg::push_t     push;
  utt_pkg::pkt_t      head;
  utt_pkg::q_status_t q_status;
  logic               pop;

  // decoder
  utt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_in),
    .q_status (q_status),
    .push     (push)
  );

  // packet queue
  utt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  // result serializer
  utt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_status.empty),
    .pop      (pop),
    .unit_out (unit_out)
  );

`ifndef SYNTH
  a_zero_budget: assert property (@(posedge clk) disable iff (rst)
    (byte_in.valid && byte_in.ready && byte_in.first_byte && byte_in.unit_budget == 16'h0)
    |-> (push.valid && push.pkt.n == 2'd1 && push.pkt.res[0].is_finish))
    else $error("zero budget string did not give a lone finish");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !q_status.full)
    else $error("packet pushed into full queue");
  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("packet popped from empty queue");
  a_unit_count: assert property (@(posedge clk) disable iff (rst)
    (unit_out.valid && !unit_out.is_finish) |-> (unit_out.units_written != '0))
    else $error("code unit sent with zero count");
`endif

endmodule

[design/utt_front.sv]
// front end: byte decoder and unit counters, builds one result packet per byte, pushed when it holds results
module utt_front (
  input  logic                clk,
  input  logic                rst,
  utt_in_if.sink              byte_in,
  input  utt_pkg::q_status_t  q_status,
  output utt_pkg::push_t      push
);

  typedef struct packed {
    logic          done;
    utt_pkg::cnt_t wcount;
    utt_pkg::cnt_t npos;
    utt_pkg::cnt_t budget;
  } ctr_t;

  typedef struct packed {
    logic [20:0] acc;
    logic [1:0]  pending;
    logic [7:0]  lo;
    logic [7:0]  hi;
    ctr_t        c;
  } st_t;

  typedef struct packed {
    ctr_t          c;
    utt_pkg::pkt_t p;
  } em_t;

  typedef struct packed {
    st_t           s;
    utt_pkg::pkt_t p;
  } step_t;

  st_t   st;
  st_t   st_next;
  step_t stp;
  logic  accept;

  // append one result to the packet
  function automatic em_t put_res(em_t e, logic [15:0] unit, utt_pkg::cnt_t pos,
                                  logic fin, utt_pkg::cnt_t cnt);
    utt_pkg::res_t r;
    em_t           o;
    o = e;
    r.code_unit     = unit;
    r.unit_position = pos;
    r.is_finish     = fin;
    r.units_written = cnt;
    unique case (e.p.n)
      2'd0: o.p.res[0] = r;
      2'd1: o.p.res[1] = r;
      2'd2: o.p.res[2] = r;
      default: ;
    endcase
    if (e.p.n != 2'd3) o.p.n = e.p.n + 2'd1;
    return o;
  endfunction

  function automatic em_t write_unit(em_t e, logic [15:0] unit);
    em_t o;
    o = e;
    if (o.c.wcount != utt_pkg::COUNT_MAX) o.c.wcount = o.c.wcount + 1'b1;
    if (o.c.budget != '0) o.c.budget = o.c.budget - 1'b1;
    o = put_res(o, unit, o.c.npos, 1'b0, o.c.wcount);
    if (o.c.npos != utt_pkg::COUNT_MAX) o.c.npos = o.c.npos + 1'b1;
    return o;
  endfunction

  function automatic em_t finish(em_t e);
    em_t o;
    o = put_res(e, 16'h0000, e.c.npos, 1'b1, e.c.wcount);
    o.c.done = 1'b1;
    return o;
  endfunction

  // one code point as one unit or a surrogate pair
  function automatic em_t emit(em_t e, logic [20:0] cp);
    logic [20:0] d;
    logic [15:0] hs;
    logic [15:0] ls;
    em_t         o;
    if (e.c.done || e.c.budget == '0) return e;
    if (cp < utt_pkg::SUPP_BASE) begin
      o = write_unit(e, cp[15:0]);
    end else begin
      d  = cp - utt_pkg::SUPP_BASE;
      hs = utt_pkg::HIGH_SURR + {6'b0, d[19:10]};
      ls = utt_pkg::LOW_SURR + {6'b0, d[9:0]};
      o = write_unit(e, hs);
      if (o.c.budget == '0) return finish(o);
      o = write_unit(o, ls);
    end
    if (o.c.budget == '0) o = finish(o);
    return o;
  endfunction

  function automatic step_t mk(st_t s, em_t e);
    step_t r;
    r.s   = s;
    r.s.c = e.c;
    r.p   = e.p;
    return r;
  endfunction

  // full decode step for one byte
  function automatic step_t step(st_t cur, logic [7:0] b, logic first,
                                 logic [15:0] ub, logic [15:0] sp);
    st_t s;
    em_t e;
    s   = cur;
    e.c = cur.c;
    e.p = '0;
    if (first) begin
      s.acc     = '0;
      s.pending = 2'd0;
      s.lo      = utt_pkg::CONT_LOW;
      s.hi      = utt_pkg::CONT_HIGH;
      e.c.done   = 1'b0;
      e.c.wcount = '0;
      e.c.npos   = utt_pkg::cnt_t'(sp);
      e.c.budget = utt_pkg::cnt_t'(ub);
      if (e.c.budget == '0) return mk(s, finish(e));
    end
    if (e.c.done) return mk(s, e);
    if (s.pending != 2'd0) begin
      if (b >= s.lo && b <= s.hi) begin
        s.acc     = {s.acc[14:0], b[5:0]};
        s.lo      = utt_pkg::CONT_LOW;
        s.hi      = utt_pkg::CONT_HIGH;
        s.pending = s.pending - 2'd1;
        if (s.pending == 2'd0) begin
          e     = emit(e, s.acc);
          s.acc = '0;
        end
        return mk(s, e);
      end
      s.acc     = '0;
      s.pending = 2'd0;
      s.lo      = utt_pkg::CONT_LOW;
      s.hi      = utt_pkg::CONT_HIGH;
      e = emit(e, {5'b0, utt_pkg::REPLACEMENT});
      if (e.c.done) return mk(s, e);
    end
    // lead byte
    if (b == 8'h00) begin
      e = finish(e);
    end else if (b < 8'h80) begin
      e = emit(e, {13'b0, b});
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      s.acc     = {16'b0, b[4:0]};
      s.pending = 2'd1;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      s.acc     = {17'b0, b[3:0]};
      s.pending = 2'd2;
      if (b == 8'hE0) s.lo = 8'hA0;
      if (b == 8'hED) s.hi = 8'h9F;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      s.acc     = {18'b0, b[2:0]};
      s.pending = 2'd3;
      if (b == 8'hF0) s.lo = 8'h90;
      if (b == 8'hF4) s.hi = 8'h8F;
    end else begin
      e = emit(e, {5'b0, utt_pkg::REPLACEMENT});
    end
    return mk(s, e);
  endfunction

  // accept whenever the queue has room
  assign byte_in.ready = !q_status.full;
  assign accept        = byte_in.valid && byte_in.ready;

  always_comb begin
    stp = step(st, byte_in.data_byte, byte_in.first_byte, byte_in.unit_budget,
               byte_in.start_position);
    st_next    = accept ? stp.s : st;
    push.valid = accept && (stp.p.n != 2'd0);
    push.pkt   = stp.p;
  end

  // decoder and counter state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.acc      <= '0;
      st.pending  <= 2'd0;
      st.lo       <= utt_pkg::CONT_LOW;
      st.hi       <= utt_pkg::CONT_HIGH;
      st.c.done   <= 1'b1;
      st.c.wcount <= '0;
      st.c.npos   <= '0;
      st.c.budget <= '0;
    end else begin
      st <= st_next;
    end
  end

endmodule

[design/utt_queue.sv]
// small packet queue between decoder and result serializer
module utt_queue (
  input  logic                clk,
  input  logic                rst,
  input  utt_pkg::push_t      push,
  input  logic                pop,
  output utt_pkg::pkt_t       head,
  output utt_pkg::q_status_t  q_status
);

  utt_pkg::pkt_t    mem [utt_pkg::QUEUE_DEPTH];
  utt_pkg::qptr_t   wr_ptr;
  utt_pkg::qptr_t   rd_ptr;
  utt_pkg::qlevel_t level;
  logic             do_push;
  logic             do_pop;

  assign q_status.full  = (level == utt_pkg::QUEUE_FULL);
  assign q_status.empty = (level == '0);
  assign q_status.level = level;
  assign do_push        = push.valid && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head           = mem[rd_ptr];

  // packet storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push.pkt;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

[design/utt_back.sv]
// back end: walks each packet and sends one result per beat
module utt_back (
  input  logic                clk,
  input  logic                rst,
  input  utt_pkg::pkt_t       head,
  input  logic                empty,
  output logic                pop,
  utt_out_if.source           unit_out
);

  utt_pkg::rcount_t idx;
  utt_pkg::res_t    cur;
  utt_pkg::res_t    out_res;
  logic             out_valid;
  logic             load;
  logic             last;

  // pick the next result of the head packet
  always_comb begin
    unique case (idx)
      2'd0:    cur = head.res[0];
      2'd1:    cur = head.res[1];
      default: cur = head.res[2];
    endcase
  end

  assign load = !empty && (!out_valid || unit_out.ready);
  assign last = (idx == head.n - 2'd1);
  assign pop  = load && last;

  // result index within the packet
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (load) begin
      idx <= last ? 2'd0 : idx + 2'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (unit_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_res <= cur;
  end

  assign unit_out.valid         = out_valid;
  assign unit_out.code_unit     = out_res.code_unit;
  assign unit_out.unit_position = out_res.unit_position;
  assign unit_out.is_finish     = out_res.is_finish;
  assign unit_out.units_written = out_res.units_written;

endmodule

[tb/sv/utf8_to_utf16_transcoder_checker.sv]
// checker for the utf-8 to utf-16 transcoder: predicts code units from byte beats and compares
module utf8_to_utf16_transcoder_checker
  import utt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  utt_in_if    byte_in,
  utt_out_if   unit_out,
  output int   fail_count,
  output int   pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  // decoder state kept alongside the block
  logic [20:0] partial_cp;
  logic [1:0]  cont_left;
  logic [7:0]  cont_min;
  logic [7:0]  cont_max;
  cnt_t        units_done;
  cnt_t        write_pos;
  cnt_t        budget_left;
  logic        string_closed;

  res_t expected_units[$];
  res_t want;

  // back to a clean decoder between sequences
  task clear_decoder();
    partial_cp = '0;
    cont_left  = '0;
    cont_min   = CONT_LOW;
    cont_max   = CONT_HIGH;
  endtask

  // finish beat carries the count and the next free position
  task close_string();
    expected_units.push_back(res_t'{code_unit: 16'h0000, unit_position: write_pos,
                                    is_finish: 1'b1, units_written: units_done});
    string_closed = 1'b1;
  endtask

  task put_unit(input logic [15:0] unit);
    if (units_done < COUNT_MAX) units_done++;
    if (budget_left != '0) budget_left--;
    expected_units.push_back(res_t'{code_unit: unit, unit_position: write_pos,
                                    is_finish: 1'b0, units_written: units_done});
    // position sticks at the top of its range
    if (write_pos < COUNT_MAX) write_pos++;
  endtask

  // one code point as one unit or a surrogate pair, cut short by the budget
  task emit_code_point(input logic [20:0] cp);
    logic [19:0] offset;
    if (string_closed || budget_left == '0) return;
    if (cp < SUPP_BASE) begin
      put_unit(cp[15:0]);
    end else begin
      offset = 20'(cp - SUPP_BASE);
      put_unit(HIGH_SURR + 16'(offset[19:10]));
      if (budget_left == '0) begin
        close_string();
        return;
      end
      put_unit(LOW_SURR + 16'(offset[9:0]));
    end
    if (budget_left == '0) close_string();
  endtask

  // expected results of one accepted byte beat
  task transcode_byte(input logic [7:0] b, input logic first, input cnt_t budget,
                      input cnt_t start);
    logic [20:0] cp;
    if (first) begin
      clear_decoder();
      string_closed = 1'b0;
      units_done    = '0;
      write_pos     = start;
      budget_left   = budget;
      if (budget == '0) begin
        close_string();
        return;
      end
    end
    if (string_closed) return;

    // continuation of a pending sequence
    if (cont_left != '0) begin
      if (b >= cont_min && b <= cont_max) begin
        partial_cp = {partial_cp[14:0], b[5:0]};
        cont_min   = CONT_LOW;
        cont_max   = CONT_HIGH;
        cont_left--;
        if (cont_left == '0) begin
          cp = partial_cp;
          partial_cp = '0;
          emit_code_point(cp);
        end
        return;
      end
      // broken sequence: replacement, then the byte is taken again as a lead
      clear_decoder();
      emit_code_point(21'(REPLACEMENT));
      if (string_closed) return;
    end

    // lead byte
    if (b == 8'h00) begin
      close_string();
    end else if (b < 8'h80) begin
      emit_code_point(21'(b));
    end else if (b >= 8'hC2 && b <= 8'hDF) begin
      partial_cp = 21'(b[4:0]);
      cont_left  = 2'd1;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      partial_cp = 21'(b[3:0]);
      cont_left  = 2'd2;
      // narrowed second byte rules out overlong forms and surrogates
      if (b == 8'hE0) cont_min = 8'hA0;
      if (b == 8'hED) cont_max = 8'h9F;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      partial_cp = 21'(b[2:0]);
      cont_left  = 2'd3;
      // overlong four-byte forms and code points past the top
      if (b == 8'hF0) cont_min = 8'h90;
      if (b == 8'hF4) cont_max = 8'h8F;
    end else begin
      emit_code_point(21'(REPLACEMENT));
    end
  endtask

  task check_field(input string field, input logic [15:0] want_v, input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %h, got %h", field, want_v, got_v);
      fail_count++;
    end
  endtask

  // predict on byte beats, compare on code unit beats
  always @(posedge clk) begin
    if (rst) begin
      clear_decoder();
      units_done    = '0;
      write_pos     = '0;
      budget_left   = '0;
      string_closed = 1'b1;
      expected_units.delete();
    end else begin
      if (byte_in.valid && byte_in.ready)
        transcode_byte(byte_in.data_byte, byte_in.first_byte, byte_in.unit_budget,
                       byte_in.start_position);
      if (unit_out.valid && unit_out.ready) begin
        if (expected_units.size() == 0) begin
          $error("unexpected beat: code_unit %h unit_position %h is_finish %b units_written %h",
                 unit_out.code_unit, unit_out.unit_position, unit_out.is_finish,
                 unit_out.units_written);
          fail_count++;
        end else begin
          want = expected_units.pop_front();
          check_field("code_unit", want.code_unit, unit_out.code_unit);
          check_field("unit_position", want.unit_position, unit_out.unit_position);
          check_field("is_finish", 16'(want.is_finish), 16'(unit_out.is_finish));
          check_field("units_written", want.units_written, unit_out.units_written);
        end
      end
    end
    pending_results = expected_units.size();
  end

endmodule

[tb/sv/utf8_to_utf16_transcoder_test.sv]
// testbench top for the utf-8 to utf-16 transcoder: byte stimulus, beat pacing and verdict
module utf8_to_utf16_transcoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import utt_pkg::*;

  localparam int     HALF_PERIOD  = 5;
  localparam int     RESET_CYCLES = 10;
  localparam int     MAX_GAP      = 18;
  localparam int     LONG_HOLD    = 100;
  localparam int     BURST_BYTES  = 40;
  localparam int     RANDOM_BYTES = 300;
  localparam int     DRAIN_CYCLES = 20;
  localparam longint TIMEOUT_NS   = 64'd5_000_000;

  // ascii extremes, two- and three-byte forms, broken sequences, invalid leads,
  // the top code point and an incomplete sequence cut by nul
  localparam logic [7:0] MIXED_TEXT [20] = '{
    8'h41, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hE0, 8'h80, 8'hED,
    8'hA0, 8'hF4, 8'h90, 8'hFF, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hC3, 8'h00};
  localparam logic [20:0] EDGE_POINTS [7] = '{
    21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hFFFF, 21'h10000, 21'h10FFFF};

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending_results;
  bit   src_eager;
  bit   sink_eager;
  bit   long_hold_req;
  int   beats_taken;

  utt_in_if  byte_in();
  utt_out_if unit_out();

  utf8_to_utf16_transcoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (byte_in),
    .unit_out (unit_out)
  );

  utf8_to_utf16_transcoder_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .byte_in         (byte_in),
    .unit_out        (unit_out),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always #HALF_PERIOD clk = ~clk;

  // one byte beat after a random gap; budget and start are noise off the first byte
  task automatic send_byte(input logic [7:0] b, input logic first, input cnt_t budget,
                           input cnt_t start);
    int gap;
    gap = src_eager ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAX_GAP));
    if (gap > 0) begin
      @(negedge clk) byte_in.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    byte_in.valid          <= 1'b1;
    byte_in.data_byte      <= b;
    byte_in.first_byte     <= first;
    byte_in.unit_budget    <= first ? budget : cnt_t'($urandom);
    byte_in.start_position <= first ? start : cnt_t'($urandom);
    do @(posedge clk); while (!byte_in.ready);
  endtask

  task automatic pause_until_drained();
    @(negedge clk) byte_in.valid <= 1'b0;
    wait (pending_results == 0);
  endtask

  // mostly well-formed text with random content, some broken sequences and stray bytes
  task automatic send_random_string(output int counted);
    logic [7:0]  text[$];
    logic [7:0]  seq[$];
    logic [20:0] cp;
    cnt_t        budget;
    cnt_t        start;
    int          n_points;
    int          keep;
    int          tail;
    case ($urandom_range(0, 9))
      0:       budget = '0;
      1:       budget = cnt_t'($urandom);
      2:       budget = cnt_t'($urandom_range(1, 3));
      default: budget = cnt_t'($urandom_range(4, 40));
    endcase
    start = ($urandom_range(0, 4) == 0) ? COUNT_MAX - cnt_t'($urandom_range(0, 6))
                                        : cnt_t'($urandom);
    n_points  = $urandom_range(0, 10);
    src_eager = ($urandom_range(0, 3) == 0);
    tail      = 0;
    for (int i = 0; i < n_points; i++) begin
      case ($urandom_range(0, 4))
        0:       cp = 21'($urandom_range(1, 'h7F));
        1:       cp = 21'($urandom_range('h80, 'h7FF));
        2:       cp = 21'($urandom_range('h800, 'hFFFF));
        3:       cp = 21'($urandom_range('h10000, 'h10FFFF));
        default: cp = EDGE_POINTS[$urandom_range(0, 6)];
      endcase
      if (cp < 21'h80)
        seq = '{cp[7:0]};
      else if (cp < 21'h800)
        seq = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
      else if (cp < 21'h10000)
        seq = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
      else
        seq = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]}, {2'b10, cp[11:6]},
                {2'b10, cp[5:0]}};
      // now and then a truncated sequence or a stray byte in front
      case ($urandom_range(0, 15))
        0: begin
          if (seq.size() > 1) begin
            keep = $urandom_range(1, seq.size() - 1);
            while (seq.size() > keep) void'(seq.pop_back());
          end
        end
        1:       seq.push_front(8'($urandom));
        default: ;
      endcase
      foreach (seq[k]) text.push_back(seq[k]);
    end
    // most strings end in nul; some are cut by the next first byte, some trail ignored bytes
    case ($urandom_range(0, 9))
      7: begin
        if (text.size() == 0) text.push_back(8'($urandom));
      end
      8, 9: begin
        text.push_back(8'h00);
        tail = $urandom_range(1, 3);
        repeat (tail) text.push_back(8'($urandom));
      end
      default: text.push_back(8'h00);
    endcase
    counted = text.size() - tail;
    foreach (text[i]) send_byte(text[i], i == 0, budget, start);
  endtask

  // receiver: random stalls per beat, eager stretches, one long hold on request
  initial begin : sink_side
    int stall;
    unit_out.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else if (sink_eager) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        @(negedge clk) unit_out.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) unit_out.ready <= 1'b1;
      do @(posedge clk); while (!unit_out.valid);
      beats_taken++;
      if (beats_taken % 32 == 0) sink_eager = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin : stimulus
    int counted;
    int counted_total;
    byte_in.valid          = 1'b0;
    byte_in.data_byte      = '0;
    byte_in.first_byte     = 1'b0;
    byte_in.unit_budget    = '0;
    byte_in.start_position = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // zero budget gives only a finish; the next byte falls on an idle block
    send_byte(8'h41, 1'b1, 16'd0, 16'd5);
    send_byte(8'h41, 1'b0, 16'd9, 16'd9);
    // a pending four-byte lead dropped silently by a restart
    send_byte(8'hF4, 1'b1, 16'd3, COUNT_MAX - cnt_t'(1));
    // budget of one: high surrogate alone, then finish
    send_byte(8'hF0, 1'b1, 16'd1, 16'd10);
    send_byte(8'h90, 1'b0, 16'd0, 16'd0);
    send_byte(8'h80, 1'b0, 16'd0, 16'd0);
    send_byte(8'h80, 1'b0, 16'd0, 16'd0);
    // mixed text running into position saturation
    foreach (MIXED_TEXT[i])
      send_byte(MIXED_TEXT[i], i == 0, COUNT_MAX, COUNT_MAX - cnt_t'(1));
    pause_until_drained();

    // receiver holds off while bytes keep coming at full rate
    long_hold_req = 1'b1;
    src_eager     = 1'b1;
    for (int i = 0; i < BURST_BYTES; i++)
      send_byte(8'($urandom_range('h20, 'h7E)), i == 0, 16'd200, 16'h1234);
    pause_until_drained();

    // random strings
    counted_total = 0;
    while (counted_total < RANDOM_BYTES) begin
      send_random_string(counted);
      counted_total += counted;
      if ($urandom_range(0, 7) == 0) pause_until_drained();
    end
    pause_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_results == 0)
      $display("utf8_to_utf16_transcoder test passed");
    else
      $display("utf8_to_utf16_transcoder test failed");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("utf8_to_utf16_transcoder test failed");
    $finish;
  end

endmodule

[sim.f]
design/utt_pkg.sv
design/utt_if.sv
design/utt_front.sv
design/utt_queue.sv
design/utt_back.sv
design/utf8_to_utf16_transcoder.sv
tb/sv/utf8_to_utf16_transcoder_checker.sv
tb/sv/utf8_to_utf16_transcoder_test.sv
